// ----- hw/rtl/phong_light_shader_defines.svh -----
// Assertion macros shared by the shader checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PHONG_LIGHT_SHADER_DEFINES_SVH
`define PHONG_LIGHT_SHADER_DEFINES_SVH

`define PLS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define PLS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pls_pkg.sv -----
// Shared widths, register indexes, sideband struct and table builders
// for the Phong light shader. No dependencies.
package pls_pkg;

	localparam int SNL_W  = 34;
	localparam int R_W    = 23;
	localparam int RAD_W  = 46;
	localparam int ROOT_W = 23;
	localparam int SVR_W  = 41;
	localparam int COS_W  = 17;
	localparam int D_W    = 22;
	localparam int W_W    = 25;
	localparam int EXP_W  = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHINE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;

	localparam logic [15:0] SHINE_RESET = 16'd256;
	localparam logic [15:0] SCALE_RESET = 16'd4096;
	localparam logic [15:0] SHADE_MAX   = 16'd32768;

	typedef struct packed {
		logic           refl_zero;
		logic [D_W-1:0] dw;
		logic [15:0]    lr;
		logic [15:0]    lg;
		logic [15:0]    lb;
	} side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] xr;
		logic [63:0] res;
		logic [63:0] bitv;
		xr = x;
		res = '0;
		bitv = 64'h1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (xr >= res + bitv) begin
				xr = xr - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] log_entry(input int b, input int i);
		logic [63:0] v;
		logic [15:0] r;
		v = ((64'h1 << b) + 64'(i)) << (30 - b);
		r = '0;
		for (int k = 0; k < 16; k++) begin
			v = (v * v) >> 30;
			r = {r[14:0], 1'b0};
			if (v >= 64'h8000_0000) begin
				r[0] = 1'b1;
				v = v >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [EXP_W-1:0] exp_entry(input int b, input int i);
		logic [63:0] root [0:14];
		logic [63:0] acc;
		for (int k = 0; k < 15; k++) begin
			root[k] = '0;
		end
		root[1] = isqrt64(64'h1 << 61);
		for (int k = 2; k <= b; k++) begin
			root[k] = isqrt64(root[k-1] << 30);
		end
		acc = 64'h1 << 30;
		for (int k = 1; k <= b; k++) begin
			if (((i >> (b - k)) & 1) != 0) begin
				acc = (acc * root[k]) >> 30;
			end
		end
		return acc[30:14];
	endfunction

endpackage

// ----- hw/rtl/pls_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on pls_pkg; carries the dot product and sideband alongside.
module pls_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [pls_pkg::RAD_W-1:0]     rad,
	input  logic signed [pls_pkg::SVR_W-1:0] svr_in,
	input  pls_pkg::side_t                side_in,
	output logic                          out_vld,
	output logic [pls_pkg::ROOT_W-1:0]    root,
	output logic signed [pls_pkg::SVR_W-1:0] svr_out,
	output pls_pkg::side_t                side_out
);
	import pls_pkg::*;

	logic                    vld_s  [ROOT_W];
	logic [RAD_W-1:0]        rem_s  [ROOT_W];
	logic [RAD_W-1:0]        res_s  [ROOT_W];
	logic signed [SVR_W-1:0] svr_s  [ROOT_W];
	side_t                   side_s [ROOT_W];

	logic [RAD_W-1:0] rem_in  [ROOT_W];
	logic [RAD_W-1:0] res_in  [ROOT_W];
	logic [RAD_W-1:0] trial   [ROOT_W];
	logic [RAD_W-1:0] step    [ROOT_W];
	logic [RAD_W-1:0] rem_nx  [ROOT_W];
	logic [RAD_W-1:0] res_nx  [ROOT_W];

	always_comb begin
		rem_in[0] = rad;
		res_in[0] = '0;
		for (int k = 1; k < ROOT_W; k++) begin
			rem_in[k] = rem_s[k-1];
			res_in[k] = res_s[k-1];
		end
		for (int k = 0; k < ROOT_W; k++) begin
			step[k] = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
			trial[k] = res_in[k] + step[k];
			if (rem_in[k] >= trial[k]) begin
				rem_nx[k] = rem_in[k] - trial[k];
				res_nx[k] = (res_in[k] >> 1) + step[k];
			end else begin
				rem_nx[k] = rem_in[k];
				res_nx[k] = res_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < ROOT_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			svr_s[0] <= svr_in;
			side_s[0] <= side_in;
			for (int k = 1; k < ROOT_W; k++) begin
				svr_s[k] <= svr_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < ROOT_W; k++) begin
				rem_s[k] <= rem_nx[k];
				res_s[k] <= res_nx[k];
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = res_s[ROOT_W-1][ROOT_W-1:0];
	assign svr_out  = svr_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

// ----- hw/rtl/pls_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pls_pkg; gives the cosine of the view and reflection vectors.
module pls_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [pls_pkg::SVR_W-1:0]  dividend,
	input  logic [pls_pkg::ROOT_W-1:0] divisor,
	input  pls_pkg::side_t             side_in,
	output logic                       out_vld,
	output logic [pls_pkg::COS_W-1:0]  quot,
	output pls_pkg::side_t             side_out
);
	import pls_pkg::*;

	logic              vld_s  [COS_W];
	logic [SVR_W-1:0]  rem_s  [COS_W];
	logic [COS_W-1:0]  q_s    [COS_W];
	logic [ROOT_W-1:0] dvs_s  [COS_W];
	side_t             side_s [COS_W];

	logic [SVR_W-1:0]  rem_in [COS_W];
	logic [COS_W-1:0]  q_in   [COS_W];
	logic [ROOT_W-1:0] dvs_in [COS_W];
	logic [SVR_W-1:0]  shd    [COS_W];
	logic [SVR_W-1:0]  rem_nx [COS_W];
	logic [COS_W-1:0]  q_nx   [COS_W];

	always_comb begin
		rem_in[0] = dividend;
		q_in[0]   = '0;
		dvs_in[0] = divisor;
		for (int j = 1; j < COS_W; j++) begin
			rem_in[j] = rem_s[j-1];
			q_in[j]   = q_s[j-1];
			dvs_in[j] = dvs_s[j-1];
		end
		for (int j = 0; j < COS_W; j++) begin
			shd[j] = SVR_W'(dvs_in[j]) << (COS_W - 1 - j);
			q_nx[j] = q_in[j];
			if (rem_in[j] >= shd[j]) begin
				rem_nx[j] = rem_in[j] - shd[j];
				q_nx[j][COS_W-1-j] = 1'b1;
			end else begin
				rem_nx[j] = rem_in[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < COS_W; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int j = 1; j < COS_W; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int j = 1; j < COS_W; j++) side_s[j] <= side_s[j-1];
			for (int j = 0; j < COS_W; j++) begin
				rem_s[j] <= rem_nx[j];
				q_s[j]   <= q_nx[j];
				dvs_s[j] <= dvs_in[j];
			end
		end
	end

	assign out_vld  = vld_s[COS_W-1];
	assign quot     = q_s[COS_W-1];
	assign side_out = side_s[COS_W-1];

endmodule

// ----- hw/rtl/pls_pow.sv -----
// Specular power stage: cosine to the shininess power via log2/exp2 tables.
// Depends on pls_pkg for widths, sideband and table builders.
module pls_pow #(
	parameter int POW_TABLE_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [pls_pkg::COS_W-1:0] cos_in,
	input  pls_pkg::side_t            side_in,
	input  logic [15:0]               shine,
	output logic                      out_vld,
	output logic [pls_pkg::W_W-1:0]   w,
	output pls_pkg::side_t            side_out
);
	import pls_pkg::*;

	localparam int TSIZE = 1 << POW_TABLE_BITS;

	typedef logic [15:0]      log_rom_t [TSIZE];
	typedef logic [EXP_W-1:0] exp_rom_t [TSIZE];

	function automatic log_rom_t build_log();
		log_rom_t t;
		for (int i = 0; i < TSIZE; i++) t[i] = log_entry(POW_TABLE_BITS, i);
		return t;
	endfunction

	function automatic exp_rom_t build_exp();
		exp_rom_t t;
		for (int i = 0; i < TSIZE; i++) t[i] = exp_entry(POW_TABLE_BITS, i);
		return t;
	endfunction

	localparam log_rom_t LOG_ROM = build_log();
	localparam exp_rom_t EXP_ROM = build_exp();

	logic [3:0]                lead;
	logic [15:0]               aligned;
	logic signed [37:0]        prod;
	logic signed [13:0]        neg_e;
	logic [W_W-1:0]            w_nx;

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [POW_TABLE_BITS-1:0] idx_s1;
	logic signed [4:0]         lgi_s1;
	logic                      cz_s1, cz_s2, cz_s3, cz_s4;
	side_t                     side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [20:0]        lg_s2;
	logic signed [29:0]        t_s3;
	logic signed [13:0]        e_s4;
	logic [EXP_W-1:0]          exp_s4;
	logic [W_W-1:0]            w_s5;

	always_comb begin
		lead = '0;
		for (int k = 0; k < 16; k++) begin
			if (cos_in[k]) lead = 4'(k);
		end
		aligned = cos_in[15:0] << (4'd15 - lead);
	end

	assign prod  = 38'(lg_s2) * 38'($signed({1'b0, shine}));
	assign neg_e = -e_s4;

	always_comb begin
		priority if (side_s4.refl_zero) begin
			w_nx = '0;
		end else if (shine == '0) begin
			w_nx = W_W'(65536);
		end else if (cz_s4) begin
			w_nx = '0;
		end else if (e_s4 >= 14'sd8) begin
			w_nx = W_W'(1) << 24;
		end else if (e_s4 >= 14'sd0) begin
			w_nx = W_W'(exp_s4) << e_s4[2:0];
		end else if (e_s4 < -14'sd24) begin
			w_nx = '0;
		end else begin
			w_nx = W_W'(exp_s4) >> neg_e[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= aligned[14 -: POW_TABLE_BITS];
			lgi_s1  <= $signed({1'b0, lead}) - 5'sd13;
			cz_s1   <= (cos_in == '0);
			side_s1 <= side_in;

			lg_s2   <= $signed({lgi_s1, LOG_ROM[idx_s1]});
			cz_s2   <= cz_s1;
			side_s2 <= side_s1;

			t_s3    <= prod[37:8];
			cz_s3   <= cz_s2;
			side_s3 <= side_s2;

			e_s4    <= t_s3[29:16];
			exp_s4  <= EXP_ROM[t_s3[15 -: POW_TABLE_BITS]];
			cz_s4   <= cz_s3;
			side_s4 <= side_s3;

			w_s5    <= w_nx;
			side_s5 <= side_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign w        = w_s5;
	assign side_out = side_s5;

endmodule

// ----- hw/rtl/phong_light_shader.sv -----
// Phong light shader: takes one surface point per clock while item_ready is high
// and returns one shaded colour for each. The depth is set by the square root of
// the reflection length (23 stages, one root bit each) and the cosine divider (17
// stages, one quotient bit each), plus 6 vector stages, 5 power stages and 4
// colour/output stages. A two-entry output buffer keeps requests flowing while one
// result waits; the pipeline holds only when both entries are full. Registers are
// written through the configuration channel, which is always ready.
// Depends on pls_pkg, pls_isqrt, pls_div and pls_pow.
module phong_light_shader #(
	parameter int POW_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic signed [15:0]              view_x,
	input  logic signed [15:0]              view_y,
	input  logic signed [15:0]              view_z,
	input  logic signed [15:0]              norm_x,
	input  logic signed [15:0]              norm_y,
	input  logic signed [15:0]              norm_z,
	input  logic signed [15:0]              light_x,
	input  logic signed [15:0]              light_y,
	input  logic signed [15:0]              light_z,
	input  logic [15:0]                     light_red,
	input  logic [15:0]                     light_green,
	input  logic [15:0]                     light_blue,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [47:0]                     cfg_data,
	output logic                            shade_valid,
	input  logic                            shade_ready,
	output logic [15:0]                     shade_red,
	output logic [15:0]                     shade_green,
	output logic [15:0]                     shade_blue
);
	import pls_pkg::*;

	logic [47:0] ambient_q, diffuse_q, specular_q;
	logic [15:0] shine_q, scale_q;

	logic en;

	logic signed [15:0] vin [3];
	logic signed [15:0] nin [3];
	logic signed [15:0] lin [3];

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [31:0]      nl_s1 [3];
	logic signed [15:0]      v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3];
	logic signed [15:0]      n_s1 [3], n_s2 [3];
	logic signed [15:0]      l_s1 [3], l_s2 [3], l_s3 [3];
	logic [15:0]             lc_s1 [3], lc_s2 [3], lc_s3 [3], lc_s4 [3], lc_s5 [3],
	                         lc_s6 [3];
	logic signed [SNL_W-1:0] snl_s2;
	logic signed [49:0]      m_s3 [3];
	logic [D_W-1:0]          d_s3, d_s4, d_s5, d_s6;
	logic signed [R_W-1:0]   r_s4 [3];
	logic [RAD_W-1:0]        sq_s5 [3];
	logic signed [38:0]      vr_s5 [3];
	logic [RAD_W-1:0]        len2_s6;
	logic signed [SVR_W-1:0] svr_s6;

	side_t                   side6;
	logic                    sq_vld;
	logic [ROOT_W-1:0]       sq_root;
	logic signed [SVR_W-1:0] sq_svr;
	side_t                   sq_side;
	side_t                   dv_side_in;
	logic [SVR_W-1:0]        dv_dividend;
	logic                    dv_vld;
	logic [COS_W-1:0]        dv_cos;
	side_t                   dv_side;
	logic                    pw_vld;
	logic [W_W-1:0]          pw_w;
	side_t                   pw_side;
	logic [15:0]             pw_light [3];

	logic                    vld_s7, vld_s8, vld_s9;
	logic [37:0]             pd_s7 [3];
	logic [40:0]             ps_s7 [3];
	logic [31:0]             ls_s7 [3], ls_s8 [3];
	logic [27:0]             sum_s8 [3];
	logic [41:0]             sum_full [3];
	logic [59:0]             prod_s9 [3];
	logic [15:0]             shade_nx [3];

	logic                    out_vld_q, skid_vld_q;
	logic [15:0]             out_q [3];
	logic [15:0]             skid_q [3];

	assign vin = '{view_x, view_y, view_z};
	assign nin = '{norm_x, norm_y, norm_z};
	assign lin = '{light_x, light_y, light_z};

	assign en         = !skid_vld_q;
	assign item_ready = en;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q  <= '0;
			diffuse_q  <= '0;
			specular_q <= '0;
			shine_q    <= SHINE_RESET;
			scale_q    <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AMBIENT:  ambient_q  <= cfg_data;
				REG_DIFFUSE:  diffuse_q  <= cfg_data;
				REG_SPECULAR: specular_q <= cfg_data;
				REG_SHINE:    shine_q    <= cfg_data[15:0];
				REG_SCALE:    scale_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= pw_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nl_s1[i] <= nin[i] * lin[i];
				v_s1[i]  <= vin[i];
				n_s1[i]  <= nin[i];
				l_s1[i]  <= lin[i];
			end
			lc_s1 <= '{light_red, light_green, light_blue};

			snl_s2 <= SNL_W'(nl_s1[0]) + SNL_W'(nl_s1[1]) + SNL_W'(nl_s1[2]);
			v_s2   <= v_s1;
			n_s2   <= n_s1;
			l_s2   <= l_s1;
			lc_s2  <= lc_s1;

			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= 50'(snl_s2) * 50'(n_s2[i]);
			end
			d_s3  <= (snl_s2 > 0) ? snl_s2[31:10] : '0;
			v_s3  <= v_s2;
			l_s3  <= l_s2;
			lc_s3 <= lc_s2;

			for (int i = 0; i < 3; i++) begin
				r_s4[i] <= R_W'((m_s3[i] >>> 25) - 50'(l_s3[i]));
			end
			d_s4  <= d_s3;
			v_s4  <= v_s3;
			lc_s4 <= lc_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= RAD_W'(r_s4[i] * r_s4[i]);
				vr_s5[i] <= 39'(v_s4[i]) * 39'(r_s4[i]);
			end
			d_s5  <= d_s4;
			lc_s5 <= lc_s4;

			len2_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			svr_s6  <= SVR_W'(vr_s5[0]) + SVR_W'(vr_s5[1]) + SVR_W'(vr_s5[2]);
			d_s6    <= d_s5;
			lc_s6   <= lc_s5;
		end
	end

	always_comb begin
		side6 = '{refl_zero: 1'b0, dw: d_s6, lr: lc_s6[0], lg: lc_s6[1], lb: lc_s6[2]};
	end

	pls_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.rad      (len2_s6),
		.svr_in   (svr_s6),
		.side_in  (side6),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.svr_out  (sq_svr),
		.side_out (sq_side)
	);

	always_comb begin
		dv_side_in = sq_side;
		dv_side_in.refl_zero = (sq_root == '0);
		dv_dividend = (sq_svr > 0) ? SVR_W'(sq_svr) : '0;
	end

	pls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.dividend (dv_dividend),
		.divisor  (sq_root),
		.side_in  (dv_side_in),
		.out_vld  (dv_vld),
		.quot     (dv_cos),
		.side_out (dv_side)
	);

	pls_pow #(
		.POW_TABLE_BITS (POW_TABLE_BITS)
	) u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dv_vld),
		.cos_in   (dv_cos),
		.side_in  (dv_side),
		.shine    (shine_q),
		.out_vld  (pw_vld),
		.w        (pw_w),
		.side_out (pw_side)
	);

	assign pw_light = '{pw_side.lr, pw_side.lg, pw_side.lb};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_full[c] = {10'b0, ambient_q[47-16*c -: 16], 16'b0} + 42'(pd_s7[c])
			            + 42'(ps_s7[c]);
			shade_nx[c] = (prod_s9[c][59:27] > 33'(SHADE_MAX)) ? SHADE_MAX
			            : prod_s9[c][42:27];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pd_s7[c]   <= 38'(pw_side.dw) * 38'(diffuse_q[47-16*c -: 16]);
				ps_s7[c]   <= 41'(pw_w) * 41'(specular_q[47-16*c -: 16]);
				ls_s7[c]   <= 32'(pw_light[c]) * 32'(scale_q);
				sum_s8[c]  <= sum_full[c][41:14];
				ls_s8[c]   <= ls_s7[c];
				prod_s9[c] <= 60'(sum_s8[c]) * 60'(ls_s8[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !shade_ready) begin
			if (en && vld_s9) skid_vld_q <= 1'b1;
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !shade_ready) begin
			if (en && vld_s9) skid_q <= shade_nx;
		end else if (skid_vld_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= shade_nx;
		end
	end

	assign shade_valid = out_vld_q;
	assign shade_red   = out_q[0];
	assign shade_green = out_q[1];
	assign shade_blue  = out_q[2];

endmodule

// ----- hw/rtl/pls_checker.sv -----
// Port-level checks for the Phong light shader and the bind that attaches them.
// Depends on phong_light_shader_defines.svh and the top level's ports.
`include "phong_light_shader_defines.svh"

module pls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        cfg_ready,
	input logic        shade_valid,
	input logic        shade_ready,
	input logic [15:0] shade_red,
	input logic [15:0] shade_green,
	input logic [15:0] shade_blue
);

	`PLS_ASSERT_NEXT(a_shade_hold, shade_valid && !shade_ready, shade_valid && $stable(shade_red) && $stable(shade_green) && $stable(shade_blue), "shade request changed while stalled")
	`PLS_ASSERT_IMPLY(a_shade_range, shade_valid, shade_red <= 16'd32768 && shade_green <= 16'd32768 && shade_blue <= 16'd32768, "shade channel above one")
	`PLS_ASSERT_IMPLY(a_ready_when_free, !shade_valid, item_ready, "input held with empty output")
	`PLS_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration channel not ready")

endmodule

bind phong_light_shader pls_checker u_pls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item_ready),
	.cfg_ready   (cfg_ready),
	.shade_valid (shade_valid),
	.shade_ready (shade_ready),
	.shade_red   (shade_red),
	.shade_green (shade_green),
	.shade_blue  (shade_blue)
);
